/* sv/wwn_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wwn_pkg: shared definitions for the windowed waveform norm unit
// Widths, register indexes, mode codes and the status bundle of the
// multi-cycle arithmetic units.
// ----------------------------------------------------------------------------
package wwn_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_SAMPLES_DEF = 4096;
    localparam int SAMPLE_BITS_DEF = 16;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int WIN_W      = 12;

    localparam logic [CFG_IDX_W-1:0] REG_NORM_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_START = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_END   = 2'd2;

    localparam logic [WIN_W-1:0] WIN_START_RST = 12'd0;
    localparam logic [WIN_W-1:0] WIN_END_RST   = 12'd4095;

    // Norm modes.
    localparam logic MODE_L2   = 1'b0;
    localparam logic MODE_PEAK = 1'b1;

    // Result arithmetic.
    localparam int ACC_W     = 48;
    localparam int ROOT_W    = 32;
    localparam int METRIC_W  = 32;
    localparam int FRAC_BITS = 8;

    // Status of a multi-cycle unit.
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage
`default_nettype wire

/* sv/wwn_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wwn_if: valid/ready channels of the windowed waveform norm unit
// One interface for the sample stream and one for the results.
// ----------------------------------------------------------------------------
interface wwn_sample_if #(
    parameter int SAMPLE_BITS = wwn_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_sample;

    modport source (output valid, output sample, output last_sample, input ready);
    modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface wwn_result_if;
    logic                         valid;
    logic                         ready;
    logic [wwn_pkg::METRIC_W-1:0] metric;
    logic                         window_error;

    modport source (output valid, output metric, output window_error, input ready);
    modport sink   (input valid, input metric, input window_error, output ready);
endinterface
`default_nettype wire

/* sv/wwn_divider.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wwn_divider: serial restoring divider
// Unsigned quotient, one bit per cycle.
// ----------------------------------------------------------------------------
module wwn_divider #(
    parameter int DVD_W = 32,
    parameter int DVS_W = 13
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [DVD_W-1:0]   dividend,
    input  wire logic [DVS_W-1:0]   divisor,
    output logic [DVD_W-1:0]        quotient,
    output wwn_pkg::unit_stat_t     stat
);
    import wwn_pkg::*;

    localparam int STEP_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0]  quo_reg, quo_next;
    logic [DVS_W-1:0]  rem_reg, rem_next;
    logic [DVS_W-1:0]  dvs_reg, dvs_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DVS_W:0]    rem_sh;
    logic [DVS_W:0]    rem_diff;
    logic              fits;

    // One trial subtraction per cycle; quotient bits shift in from the right.
    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[DVD_W-1]};
        rem_diff = rem_sh - {1'b0, dvs_reg};
        fits     = rem_sh >= {1'b0, dvs_reg};

        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            step_next = STEP_W'(DVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next  = {quo_reg[DVD_W-2:0], fits};
            rem_next  = fits ? rem_diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
            dvs_reg  <= dvs_next;
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule
`default_nettype wire

/* sv/wwn_sqrt.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wwn_sqrt: serial integer square root
// Digit-by-digit root of a 2*ROOT_W bit radicand, one root bit per cycle.
// ----------------------------------------------------------------------------
module wwn_sqrt #(
    parameter int ROOT_W = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [2*ROOT_W-1:0]   radicand,
    output logic [ROOT_W-1:0]          root,
    output wwn_pkg::unit_stat_t        stat
);
    import wwn_pkg::*;

    localparam int RAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 2;
    localparam int STEP_W = $clog2(ROOT_W + 1);

    logic [RAD_W-1:0]  rad_reg, rad_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  rem_diff;
    logic              fits;

    // Bring down two radicand bits, try root*4+1, keep the result if it fits.
    always_comb
    begin
        rem_sh   = {rem_reg, rad_reg[RAD_W-1 -: 2]};
        trial    = (REM_W + 2)'({root_reg, 2'b01});
        rem_diff = rem_sh - trial;
        fits     = rem_sh >= trial;

        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start)
        begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            step_next = STEP_W'(ROOT_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
            rem_next  = fits ? rem_diff[REM_W-1:0] : rem_sh[REM_W-1:0];
            root_next = {root_reg[ROOT_W-2:0], fits};
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rad_reg  <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign root      = root_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule
`default_nettype wire

/* sv/windowed_waveform_norm_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// windowed_waveform_norm_unit: windowed L2 norm and peak of a waveform record
// Stores a record of samples, removes its mean and reports either the root
// of the windowed sum of squares over the window length or the peak
// magnitude in the window, with 8 fraction bits and saturation.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake       Beat contents
//  -------   ---  ---------       -------------
//  samples   in   valid / ready   sample, last_sample
//  results   out  valid / ready   metric, window_error
//  cfg       in   cfg_we only     cfg_index, cfg_data
//
//  Samples load at one beat per cycle into the sample store while
//  samples.ready is high. After the beat with last_sample the unit runs
//  a serial mean division, then streams the window out of the store at
//  one entry per cycle. L2 mode adds the serial root and the serial
//  division by the window length. samples.ready is low from the last beat
//  until the result sits in the output register; that register holds it
//  while the next record loads. Reset clears the control, configuration
//  and result registers only; the store needs no clearing pass.
//
module windowed_waveform_norm_unit #(
    parameter int MAX_SAMPLES = wwn_pkg::MAX_SAMPLES_DEF,
    parameter int SAMPLE_BITS = wwn_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    wwn_sample_if.sink                           samples,
    wwn_result_if.source                         results,
    input  wire logic                            cfg_we,
    input  wire logic [wwn_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [wwn_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import wwn_pkg::*;

    localparam int ADDR_W    = $clog2(MAX_SAMPLES);
    localparam int CNT_W     = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W     = SAMPLE_BITS + ADDR_W;
    localparam int DIV_W     = (SUM_W > ROOT_W) ? SUM_W : ROOT_W;
    localparam int IDX_W     = (WIN_W > CNT_W) ? WIN_W : CNT_W;
    localparam int C_W       = SAMPLE_BITS + 1;
    localparam int MAG_W     = SAMPLE_BITS;
    localparam int SQ_W      = 2 * SAMPLE_BITS;
    localparam int RAD_W     = 2 * ROOT_W;
    localparam int PEAK_X_W  = 2 * METRIC_W;

    typedef enum logic [5:0] {
        S_LOAD  = 6'b000001,
        S_MEAN  = 6'b000010,
        S_SCAN  = 6'b000100,
        S_ROOT  = 6'b001000,
        S_SCALE = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    // Configuration registers.
    logic             norm_mode_reg;
    logic [WIN_W-1:0] win_start_reg;
    logic [WIN_W-1:0] win_end_reg;

    // Control and result registers.
    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic signed [C_W-1:0]   mean_reg, mean_next;
    logic [ADDR_W-1:0]       rd_addr_reg, rd_addr_next;
    logic [ADDR_W-1:0]       hi_reg, hi_next;
    logic [CNT_W-1:0]        n_reg, n_next;
    logic                    issuing_reg, issuing_next;
    logic [ACC_W-1:0]        acc_reg, acc_next;
    logic [MAG_W-1:0]        best_reg, best_next;
    logic [METRIC_W-1:0]     res_metric_reg, res_metric_next;
    logic                    res_err_reg, res_err_next;
    logic                    out_valid_reg, out_valid_next;
    logic [METRIC_W-1:0]     out_metric_reg, out_metric_next;
    logic                    out_err_reg, out_err_next;

    // Scan pipeline.
    logic signed [SAMPLE_BITS-1:0] store_mem [MAX_SAMPLES];
    logic signed [SAMPLE_BITS-1:0] rd_data_reg;
    logic [MAG_W-1:0]              mag_reg;
    logic [SQ_W-1:0]               sq_reg;
    logic                          p1_reg, p2_reg, p3_reg;

    // Combinational helpers.
    logic                          in_fire;
    logic                          store_ok;
    logic signed [SAMPLE_BITS-1:0] s_in;
    logic [CNT_W-1:0]              count_upd;
    logic signed [SUM_W-1:0]       sum_upd;
    logic [SUM_W-1:0]              sum_mag;
    logic [C_W-1:0]                mean_mag;
    logic [CNT_W-1:0]              cnt_m1;
    logic [IDX_W-1:0]              lim_x, ws_x, we_x, lo_x, hi_x;
    logic                          win_empty;
    logic [ADDR_W-1:0]             lo_a, hi_a, scan_lo;
    logic signed [C_W-1:0]         c_val;
    logic [C_W-1:0]                c_abs;
    logic [ACC_W:0]                acc_sum;
    logic [PEAK_X_W-1:0]           peak_ext;
    logic [METRIC_W-1:0]           peak_sat;
    logic                          drained;
    logic                          res_take;

    // Shared unit handshakes.
    logic              div_start;
    logic [DIV_W-1:0]  div_dividend;
    logic [CNT_W-1:0]  div_divisor;
    logic [DIV_W-1:0]  div_quot;
    unit_stat_t        div_stat;
    logic              sqrt_start;
    logic [ROOT_W-1:0] sqrt_root;
    unit_stat_t        sqrt_stat;

    // Configuration writes; indexes past the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            norm_mode_reg <= MODE_L2;
            win_start_reg <= WIN_START_RST;
            win_end_reg   <= WIN_END_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_NORM_MODE:    norm_mode_reg <= cfg_data[0];
                REG_WINDOW_START: win_start_reg <= cfg_data[WIN_W-1:0];
                REG_WINDOW_END:   win_end_reg   <= cfg_data[WIN_W-1:0];
                default:          ;
            endcase
        end
    end

    // Load side: running sum and count including the current beat.
    assign s_in      = samples.sample;
    assign samples.ready = (state_reg == S_LOAD);
    assign in_fire   = samples.valid && samples.ready;
    assign store_ok  = count_reg < CNT_W'(MAX_SAMPLES);
    assign count_upd = store_ok ? count_reg + 1'b1 : count_reg;
    assign sum_upd   = store_ok ? sum_reg + SUM_W'(s_in) : sum_reg;
    assign sum_mag   = sum_upd[SUM_W-1] ? SUM_W'(-sum_upd) : SUM_W'(sum_upd);

    // Mean with truncation toward zero: signed magnitude of the quotient.
    assign mean_mag = div_quot[C_W-1:0];

    // Window bounds clamped to the last stored index.
    assign cnt_m1    = count_reg - 1'b1;
    assign lim_x     = IDX_W'(cnt_m1);
    assign ws_x      = IDX_W'(win_start_reg);
    assign we_x      = IDX_W'(win_end_reg);
    assign lo_x      = (ws_x < lim_x) ? ws_x : lim_x;
    assign hi_x      = (we_x < lim_x) ? we_x : lim_x;
    assign win_empty = lo_x > hi_x;
    assign lo_a      = lo_x[ADDR_W-1:0];
    assign hi_a      = hi_x[ADDR_W-1:0];
    assign scan_lo   = win_empty ? hi_a : lo_a;

    // Centred magnitude, saturating square accumulation and peak scaling.
    assign c_val    = C_W'(rd_data_reg) - mean_reg;
    assign c_abs    = c_val[C_W-1] ? C_W'(-c_val) : C_W'(c_val);
    assign acc_sum  = (ACC_W + 1)'(acc_reg) + (ACC_W + 1)'(sq_reg);
    assign peak_ext = PEAK_X_W'({best_reg, {FRAC_BITS{1'b0}}});
    assign peak_sat = (|peak_ext[PEAK_X_W-1:METRIC_W]) ? '1 : peak_ext[METRIC_W-1:0];

    assign drained  = !issuing_reg && !p1_reg && !p2_reg && !p3_reg;
    assign res_take = !out_valid_reg || results.ready;

    // Shared divider: mean at the last beat, window scaling after the root.
    assign div_start    = (in_fire && samples.last_sample)
                       || (state_reg == S_ROOT && sqrt_stat.done);
    assign div_dividend = (state_reg == S_LOAD) ? DIV_W'(sum_mag) : DIV_W'(sqrt_root);
    assign div_divisor  = (state_reg == S_LOAD) ? count_upd : n_reg;

    assign sqrt_start = (state_reg == S_SCAN) && drained && (norm_mode_reg == MODE_L2);

    wwn_divider #(
        .DVD_W (DIV_W),
        .DVS_W (CNT_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quot),
        .stat     (div_stat)
    );

    wwn_sqrt #(
        .ROOT_W (ROOT_W)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand ({acc_reg, {(RAD_W - ACC_W){1'b0}}}),
        .root     (sqrt_root),
        .stat     (sqrt_stat)
    );

    // Sample store: one write port for loading, one read port for the scan.
    always_ff @(posedge clk)
    begin
        if (in_fire && store_ok)
        begin
            store_mem[count_reg[ADDR_W-1:0]] <= s_in;
        end
        if (issuing_reg)
        begin
            rd_data_reg <= store_mem[rd_addr_reg];
        end
    end

    // Scan data path: centre and rectify, then square.
    always_ff @(posedge clk)
    begin
        mag_reg <= c_abs[MAG_W-1:0];
        sq_reg  <= mag_reg * mag_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_reg <= 1'b0;
            p2_reg <= 1'b0;
            p3_reg <= 1'b0;
        end
        else
        begin
            p1_reg <= issuing_reg;
            p2_reg <= p1_reg;
            p3_reg <= p2_reg;
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        sum_next        = sum_reg;
        mean_next       = mean_reg;
        rd_addr_next    = rd_addr_reg;
        hi_next         = hi_reg;
        n_next          = n_reg;
        issuing_next    = issuing_reg;
        acc_next        = acc_reg;
        best_next       = best_reg;
        res_metric_next = res_metric_reg;
        res_err_next    = res_err_reg;
        out_valid_next  = out_valid_reg && !results.ready;
        out_metric_next = out_metric_reg;
        out_err_next    = out_err_reg;

        if (p3_reg)
        begin
            acc_next = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
        end
        if (p2_reg && (mag_reg > best_reg))
        begin
            best_next = mag_reg;
        end

        case (state_reg)
            S_LOAD:
            begin
                if (in_fire)
                begin
                    count_next = count_upd;
                    sum_next   = sum_upd;
                    if (samples.last_sample)
                    begin
                        state_next = S_MEAN;
                    end
                end
            end
            S_MEAN:
            begin
                if (div_stat.done)
                begin
                    mean_next       = sum_reg[SUM_W-1] ? C_W'(-mean_mag) : C_W'(mean_mag);
                    hi_next         = hi_a;
                    n_next          = CNT_W'(hi_a) - CNT_W'(lo_a) + 1'b1;
                    rd_addr_next    = scan_lo;
                    acc_next        = '0;
                    best_next       = '0;
                    res_metric_next = '0;
                    res_err_next    = 1'b0;
                    if ((norm_mode_reg == MODE_L2) && win_empty)
                    begin
                        res_err_next = 1'b1;
                        state_next   = S_DONE;
                    end
                    else
                    begin
                        issuing_next = 1'b1;
                        state_next   = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (issuing_reg)
                begin
                    if (rd_addr_reg == hi_reg)
                    begin
                        issuing_next = 1'b0;
                    end
                    else
                    begin
                        rd_addr_next = rd_addr_reg + 1'b1;
                    end
                end
                if (drained)
                begin
                    if (norm_mode_reg == MODE_L2)
                    begin
                        state_next = S_ROOT;
                    end
                    else
                    begin
                        res_metric_next = peak_sat;
                        state_next      = S_DONE;
                    end
                end
            end
            S_ROOT:
            begin
                if (sqrt_stat.done)
                begin
                    state_next = S_SCALE;
                end
            end
            S_SCALE:
            begin
                if (div_stat.done)
                begin
                    res_metric_next = div_quot[METRIC_W-1:0];
                    state_next      = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    out_valid_next  = 1'b1;
                    out_metric_next = res_metric_reg;
                    out_err_next    = res_err_reg;
                    count_next      = '0;
                    sum_next        = '0;
                    state_next      = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            count_reg      <= '0;
            sum_reg        <= '0;
            mean_reg       <= '0;
            rd_addr_reg    <= '0;
            hi_reg         <= '0;
            n_reg          <= '0;
            issuing_reg    <= 1'b0;
            acc_reg        <= '0;
            best_reg       <= '0;
            res_metric_reg <= '0;
            res_err_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_metric_reg <= '0;
            out_err_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            sum_reg        <= sum_next;
            mean_reg       <= mean_next;
            rd_addr_reg    <= rd_addr_next;
            hi_reg         <= hi_next;
            n_reg          <= n_next;
            issuing_reg    <= issuing_next;
            acc_reg        <= acc_next;
            best_reg       <= best_next;
            res_metric_reg <= res_metric_next;
            res_err_reg    <= res_err_next;
            out_valid_reg  <= out_valid_next;
            out_metric_reg <= out_metric_next;
            out_err_reg    <= out_err_next;
        end
    end

    // Output register.
    assign results.valid        = out_valid_reg;
    assign results.metric       = out_metric_reg;
    assign results.window_error = out_err_reg;

    // Checks on the sequencer and the scan.
    a_ready_units_idle: assert property (@(posedge clk) disable iff (!rst_n)
        samples.ready |-> (!div_stat.busy && !sqrt_stat.busy))
        else $error("sample beat accepted while an arithmetic unit is busy");

    a_scan_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        issuing_reg |-> (rd_addr_reg <= hi_reg))
        else $error("scan read address beyond the clamped window end");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_SAMPLES))
        else $error("sample count exceeds the store depth");

    a_record_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && res_take) |=> (count_reg == '0 && sum_reg == '0))
        else $error("record state not cleared after the result was placed");

endmodule
`default_nettype wire

/* tb/sv/wwn_norm_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wwn_norm_checker: result checker for the windowed waveform norm unit
// Watches the sample, result and register traffic. Keeps its own copy of
// the record store, the running sum and the window settings, works out the
// metric of every finished record and compares each result beat, field by
// field, with the oldest metric still due.
// ----------------------------------------------------------------------------
module wwn_norm_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    wwn_sample_if                          samples,
    wwn_result_if                          results,
    input  logic                           cfg_we,
    input  logic [wwn_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wwn_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             fail_count,
    output int                             outstanding
);
    import wwn_pkg::*;

    localparam int REC_CAP = MAX_SAMPLES_DEF;
    localparam int SAMP_W  = SAMPLE_BITS_DEF;
    localparam longint unsigned SUMSQ_CAP  = (64'd1 << ACC_W) - 64'd1;
    localparam longint unsigned METRIC_MAX = (64'd1 << METRIC_W) - 64'd1;

    typedef struct packed {
        logic [METRIC_W-1:0] metric;
        logic                window_error;
    } norm_result_t;

    // Mirror of the record held by the unit and of its window registers.
    logic signed [SAMP_W-1:0] record_store [REC_CAP];
    longint                   record_sum;
    int                       record_len;
    logic                     mode_sel;
    logic [WIN_W-1:0]         win_first;
    logic [WIN_W-1:0]         win_last;

    norm_result_t metric_due_q [$];
    norm_result_t want;
    int           mismatches;
    int           result_no;

    // Floor of the square root, one result bit per step from the top.
    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    // Metric of the record now complete, with the window clamped to it.
    function automatic norm_result_t record_metric();
        longint          centre;
        longint          dev;
        longint unsigned mag;
        longint unsigned best;
        longint unsigned sumsq;
        int              lo;
        int              hi;
        norm_result_t    r;
        centre = record_sum / record_len;
        lo = (int'(win_first) < record_len - 1) ? int'(win_first) : record_len - 1;
        hi = (int'(win_last) < record_len - 1) ? int'(win_last) : record_len - 1;
        r.metric       = '0;
        r.window_error = 1'b0;
        if (mode_sel == MODE_L2)
        begin
            if (lo > hi)
                r.window_error = 1'b1;
            else
            begin
                sumsq = 0;
                for (int i = lo; i <= hi; i++)
                begin
                    dev = longint'(record_store[i]) - centre;
                    mag = (dev < 0) ? -dev : dev;
                    sumsq = (sumsq > SUMSQ_CAP - mag * mag) ? SUMSQ_CAP : sumsq + mag * mag;
                end
                best = floor_root(sumsq << (2 * FRAC_BITS)) / longint'(hi - lo + 1);
                r.metric = (best > METRIC_MAX) ? '1 : best[METRIC_W-1:0];
            end
        end
        else
        begin
            // Peak: the clamped end sample seeds the search, so an empty
            // window still reports that one sample.
            dev  = longint'(record_store[hi]) - centre;
            best = (dev < 0) ? -dev : dev;
            for (int i = lo; i < hi; i++)
            begin
                dev = longint'(record_store[i]) - centre;
                mag = (dev < 0) ? -dev : dev;
                if (mag > best)
                    best = mag;
            end
            best = best << FRAC_BITS;
            r.metric = (best > METRIC_MAX) ? '1 : best[METRIC_W-1:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned exp_val,
                                   input longint unsigned got_val);
        $display("result %0d: %s expected 0x%0h, got 0x%0h", result_no, what, exp_val, got_val);
        mismatches++;
    endtask

    // Result beats are retired before the sample beat of the same edge, as a
    // record finishing now cannot already have its result on the output.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            record_sum  = 0;
            record_len  = 0;
            mode_sel    = MODE_L2;
            win_first   = WIN_START_RST;
            win_last    = WIN_END_RST;
            mismatches  = 0;
            result_no   = 0;
            metric_due_q.delete();
            fail_count  <= 0;
            outstanding <= 0;
        end
        else
        begin
            // Register writes.
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_NORM_MODE:    mode_sel  = cfg_data[0];
                    REG_WINDOW_START: win_first = cfg_data[WIN_W-1:0];
                    REG_WINDOW_END:   win_last  = cfg_data[WIN_W-1:0];
                    default: ;
                endcase
            end

            // Result beat against the oldest metric due.
            if (results.valid && results.ready)
            begin
                if (metric_due_q.size() == 0)
                    report_mismatch("unexpected beat, metric", 0, results.metric);
                else
                begin
                    want = metric_due_q.pop_front();
                    if (results.metric !== want.metric)
                        report_mismatch("metric", want.metric, results.metric);
                    if (results.window_error !== want.window_error)
                        report_mismatch("window_error", want.window_error,
                                        results.window_error);
                end
                result_no++;
            end

            // Sample beat: store and sum while there is room, finish on the marker.
            if (samples.valid && samples.ready)
            begin
                if (record_len < REC_CAP)
                begin
                    record_store[record_len] = samples.sample;
                    record_sum += longint'(samples.sample);
                    record_len++;
                end
                if (samples.last_sample)
                begin
                    metric_due_q.push_back(record_metric());
                    record_sum = 0;
                    record_len = 0;
                end
            end

            fail_count  <= mismatches;
            outstanding <= metric_due_q.size();
        end
    end

endmodule

/* tb/sv/tb_windowed_waveform_norm_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_windowed_waveform_norm_unit: testbench of the windowed waveform norm unit
// Loads waveform records through the sample channel under several window
// and mode settings: a directed set of extremes, empty and clamped windows
// and one record longer than the store, then random records with random
// gaps on both channels and a long stall of the result side. A checker
// beside the unit predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module tb_windowed_waveform_norm_unit;
    import wwn_pkg::*;

    localparam int RANDOM_BEATS  = 2000;
    localparam int LONG_RECORD   = MAX_SAMPLES_DEF + 2;
    localparam int QUIET_LIMIT   = 20000;
    localparam int HOLD_CYCLES   = 600;
    localparam int SETTLE_CYCLES = 16;
    localparam int TAIL_CYCLES   = 160;

    localparam logic signed [SAMPLE_BITS_DEF-1:0] EXTREMES [5] =
        '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF, 16'sh0001};

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int holds_served  = 0;
    int quiet_cycles  = 0;
    int beats_sent    = 0;
    int fail_count;
    int outstanding;

    wwn_sample_if samples ();
    wwn_result_if results ();

    windowed_waveform_norm_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples),
        .results   (results),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    wwn_norm_checker norm_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .samples     (samples),
        .results     (results),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Result side: random stalls, plus a long hold whenever one is requested.
    initial
    begin
        results.ready <= 1'b0;
        forever
        begin
            if (holds_served != hold_requests)
            begin
                holds_served++;
                repeat (HOLD_CYCLES)
                begin
                    results.ready <= 1'b0;
                    @(posedge clk);
                end
            end
            else
            begin
                results.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
                @(posedge clk);
            end
        end
    end

    // Watchdog on cycles without any beat on either channel.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((samples.valid && samples.ready) || (results.valid && results.ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("windowed_waveform_norm_unit: mismatch");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // One sample beat, with random gaps in front of it.
    task automatic push_sample(input logic signed [SAMPLE_BITS_DEF-1:0] value,
                               input logic is_last);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            samples.valid <= 1'b0;
            @(posedge clk);
        end
        samples.valid       <= 1'b1;
        samples.sample      <= value;
        samples.last_sample <= is_last;
        do
            @(posedge clk);
        while (!samples.ready);
        beats_sent++;
    endtask

    // A whole record: full-range noise, a small spread around an offset,
    // full-scale and near-zero codes or a flat line.
    task automatic push_record(input int len);
        int                           style;
        logic signed [SAMPLE_BITS_DEF-1:0] anchor;
        logic signed [SAMPLE_BITS_DEF-1:0] value;
        style  = $urandom_range(0, 3);
        anchor = $urandom;
        for (int k = 0; k < len; k++)
        begin
            case (style)
                0:       value = $urandom;
                1:       value = anchor + $urandom_range(0, 63) - 32;
                2:       value = EXTREMES[$urandom_range(0, 4)];
                default: value = anchor;
            endcase
            push_sample(value, k == len - 1);
        end
    endtask

    // Let every due result come out and the unit fall idle.
    task automatic settle();
        samples.valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all three registers on consecutive edges.
    task automatic program_window(input logic mode, input logic [WIN_W-1:0] first_idx,
                                  input logic [WIN_W-1:0] last_idx);
        cfg_we    <= 1'b1;
        cfg_index <= REG_NORM_MODE;
        cfg_data  <= CFG_DATA_W'(mode);
        @(posedge clk);
        cfg_index <= REG_WINDOW_START;
        cfg_data  <= first_idx;
        @(posedge clk);
        cfg_index <= REG_WINDOW_END;
        cfg_data  <= last_idx;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Window bounds lean towards small records, with both extremes present.
    function automatic logic [WIN_W-1:0] pick_bound();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return WIN_W'($urandom_range(0, 8));
            3:       return WIN_W'($urandom_range(0, 24));
            4:       return WIN_W'($urandom_range(0, 80));
            default: return WIN_W'($urandom);
        endcase
    endfunction

    initial
    begin
        int directed_end;
        int progress;
        int phase_no;
        int len;

        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_index           <= REG_NORM_MODE;
        cfg_data            <= '0;
        samples.valid       <= 1'b0;
        samples.sample      <= '0;
        samples.last_sample <= 1'b0;
        phase_no = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset window in L2 mode: full-scale and near-zero codes, then a one-sample record.
        push_sample(16'sh7FFF, 1'b0);
        push_sample(16'sh8000, 1'b0);
        push_sample(16'sh0000, 1'b0);
        push_sample(16'shFFFF, 1'b1);
        push_sample(16'sh8000, 1'b1);

        // Peak over the whole record.
        settle();
        program_window(MODE_PEAK, '0, '1);
        push_sample(16'sh8000, 1'b0);
        push_sample(16'sh7FFF, 1'b0);
        push_sample(16'sh0001, 1'b1);

        // Start past end: error flag in L2 mode.
        settle();
        program_window(MODE_L2, 12'd3, 12'd1);
        for (int k = 0; k < 5; k++)
            push_sample(16'(k * 150 - 300), k == 4);

        // Same empty window in peak mode reports the end sample.
        settle();
        program_window(MODE_PEAK, 12'd3, 12'd1);
        for (int k = 0; k < 5; k++)
            push_sample(16'(k * 999 - 1500), k == 4);

        // Both bounds beyond the record clamp onto its last sample.
        settle();
        program_window(MODE_L2, '1, '1);
        push_sample(16'sh7FFF, 1'b0);
        push_sample(16'sh8000, 1'b0);
        push_sample(16'sh4000, 1'b1);

        settle();
        program_window(MODE_PEAK, '0, '0);
        push_sample(16'sh8000, 1'b0);
        push_sample(16'sh7FFF, 1'b1);

        // A record longer than the store: the surplus samples are dropped.
        settle();
        program_window(MODE_L2, '0, '1);
        push_record(LONG_RECORD);

        // Random phases: new window and mode each time, idling shifting by thirds.
        directed_end = beats_sent;
        while (beats_sent < directed_end + RANDOM_BEATS)
        begin
            progress = beats_sent - directed_end;
            if (progress < RANDOM_BEATS / 3)
            begin
                send_idle_pct = 29;
                recv_idle_pct = 66;
            end
            else if (progress < 2 * RANDOM_BEATS / 3)
            begin
                send_idle_pct = 66;
                recv_idle_pct = 29;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            settle();
            program_window($urandom_range(0, 1), pick_bound(), pick_bound());
            phase_no++;
            if (phase_no % 9 == 4)
                hold_requests++;
            repeat ($urandom_range(2, 8))
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: len = $urandom_range(1, 12);
                    6, 7, 8:          len = $urandom_range(13, 64);
                    default:          len = $urandom_range(65, 400);
                endcase
                push_record(len);
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("windowed_waveform_norm_unit: match");
        else
            $display("windowed_waveform_norm_unit: mismatch");
        $finish;
    end

endmodule
